FILE: hw/rtl/llsfl_pkg.sv
`timescale 1ns / 1ps

package llsfl_pkg;

	localparam logic [1:0] KIND_INSERT   = 2'd0;
	localparam logic [1:0] KIND_TRAVERSE = 2'd1;
	localparam logic [1:0] KIND_DELETE   = 2'd2;

	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;
	localparam logic [1:0] STATUS_ELEMENT  = 2'd3;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_INS  = 4'b0010,
		ST_DEL  = 4'b0100,
		ST_WALK = 4'b1000
	} state_t;

endpackage

FILE: hw/rtl/llsfl_in_if.sv
`timescale 1ns / 1ps

interface llsfl_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [31:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

FILE: hw/rtl/llsfl_out_if.sv
`timescale 1ns / 1ps

interface llsfl_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] element;
	logic               last;

	modport source (output valid, output status, output element, output last, input ready);
	modport sink (input valid, input status, input element, input last, output ready);
endinterface

FILE: hw/rtl/linked_list_stack_with_free_list.sv
`timescale 1ns / 1ps

// channel   dir  fields                          item
// in_ch     in   kind[1:0], value[31:0]          one list command
// out_ch    out  status[1:0], element[31:0], last  one result, last marks the end
//
// Insert and delete do one link memory read, then the link write.
// Traverse gives one result per element; empty, overflow and unused kinds give one result.
// The single link memory read port paces the walk at one element per cycle while the output is not stalled.
// Reset clears head pointers and the fresh-node count at once; no clearing pass.
// A stalled result holds the output register and freezes the sequencer.

module linked_list_stack_with_free_list #(
	parameter int unsigned NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	llsfl_in_if.sink    in_ch,
	llsfl_out_if.source out_ch
);

	localparam int unsigned AW = $clog2(NODES);
	localparam int unsigned LW = $clog2(NODES + 1);
	localparam logic [LW-1:0] LINK_NULL = LW'(NODES);
	localparam logic [AW-1:0] LAST_COUNT = AW'(NODES - 1);
	localparam int unsigned VALUE_W_L = llsfl_pkg::VALUE_W;

	llsfl_pkg::state_t state_q, state_n;

	logic [LW-1:0] free_head_q, free_head_n;
	logic [LW-1:0] list_head_q, list_head_n;
	logic [LW-1:0] fresh_q, fresh_n;
	logic [AW-1:0] node_q, node_n;
	logic [AW-1:0] count_q, count_n;

	logic          lk_we, lk_re;
	logic [AW-1:0] lk_waddr, lk_raddr;
	logic [LW-1:0] lk_wdata, lk_rdata;
	logic [AW-1:0] raddr_s1;
	logic          fresh_s1;
	logic [LW-1:0] link_eff;

	logic                 val_we, val_re;
	logic [AW-1:0]        val_waddr, val_raddr;
	logic [VALUE_W_L-1:0] val_rdata;

	logic               out_v_q;
	logic [1:0]         out_status_q;
	logic signed [31:0] out_element_q;
	logic               out_last_q;

	logic               emit;
	logic [1:0]         e_status;
	logic signed [31:0] e_element;
	logic               e_last;
	logic               can_emit;
	logic               accept;
	logic               walk_end;

	assign can_emit = !out_v_q || out_ch.ready;
	assign in_ch.ready = (state_q == llsfl_pkg::ST_IDLE) && can_emit;
	assign accept = in_ch.valid && in_ch.ready;

	assign link_eff = fresh_s1 ? (LW'(raddr_s1) + LW'(1)) : lk_rdata;
	assign walk_end = (link_eff >= LINK_NULL) || (count_q == LAST_COUNT);

	llsfl_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (lk_re),
		.raddr (lk_raddr),
		.rdata (lk_rdata)
	);

	llsfl_ram #(.WIDTH(VALUE_W_L), .DEPTH(NODES)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (in_ch.value),
		.re    (val_re),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	always_comb begin
		state_n     = state_q;
		free_head_n = free_head_q;
		list_head_n = list_head_q;
		fresh_n     = fresh_q;
		node_n      = node_q;
		count_n     = count_q;
		lk_we       = 1'b0;
		lk_waddr    = node_q;
		lk_wdata    = list_head_q;
		lk_re       = 1'b0;
		lk_raddr    = list_head_q[AW-1:0];
		val_we      = 1'b0;
		val_waddr   = free_head_q[AW-1:0];
		val_re      = 1'b0;
		val_raddr   = list_head_q[AW-1:0];
		emit        = 1'b0;
		e_status    = llsfl_pkg::STATUS_DONE;
		e_element   = '0;
		e_last      = 1'b1;
		case (state_q)
			llsfl_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_ch.kind)
						llsfl_pkg::KIND_INSERT: begin
							if (free_head_q == LINK_NULL) begin
								emit     = 1'b1;
								e_status = llsfl_pkg::STATUS_OVERFLOW;
							end else begin
								lk_re    = 1'b1;
								lk_raddr = free_head_q[AW-1:0];
								val_we   = 1'b1;
								node_n   = free_head_q[AW-1:0];
								state_n  = llsfl_pkg::ST_INS;
							end
						end
						llsfl_pkg::KIND_DELETE: begin
							if (list_head_q == LINK_NULL) begin
								emit     = 1'b1;
								e_status = llsfl_pkg::STATUS_EMPTY;
							end else begin
								lk_re   = 1'b1;
								node_n  = list_head_q[AW-1:0];
								state_n = llsfl_pkg::ST_DEL;
							end
						end
						llsfl_pkg::KIND_TRAVERSE: begin
							if (list_head_q == LINK_NULL) begin
								emit     = 1'b1;
								e_status = llsfl_pkg::STATUS_EMPTY;
							end else begin
								lk_re   = 1'b1;
								val_re  = 1'b1;
								count_n = '0;
								state_n = llsfl_pkg::ST_WALK;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			llsfl_pkg::ST_INS: begin
				if (can_emit) begin
					lk_we       = 1'b1;
					lk_wdata    = list_head_q;
					free_head_n = link_eff;
					list_head_n = LW'(node_q);
					if (LW'(node_q) == fresh_q) begin
						fresh_n = fresh_q + LW'(1);
					end
					emit    = 1'b1;
					state_n = llsfl_pkg::ST_IDLE;
				end
			end
			llsfl_pkg::ST_DEL: begin
				if (can_emit) begin
					lk_we       = 1'b1;
					lk_wdata    = free_head_q;
					list_head_n = link_eff;
					free_head_n = LW'(node_q);
					emit        = 1'b1;
					state_n     = llsfl_pkg::ST_IDLE;
				end
			end
			llsfl_pkg::ST_WALK: begin
				if (can_emit) begin
					emit      = 1'b1;
					e_status  = llsfl_pkg::STATUS_ELEMENT;
					e_element = val_rdata;
					e_last    = walk_end;
					if (walk_end) begin
						state_n = llsfl_pkg::ST_IDLE;
					end else begin
						lk_re     = 1'b1;
						val_re    = 1'b1;
						lk_raddr  = link_eff[AW-1:0];
						val_raddr = link_eff[AW-1:0];
						count_n   = count_q + AW'(1);
					end
				end
			end
			default: begin
				state_n = llsfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= llsfl_pkg::ST_IDLE;
			free_head_q <= '0;
			list_head_q <= LINK_NULL;
			fresh_q     <= '0;
			out_v_q     <= 1'b0;
		end else begin
			state_q     <= state_n;
			free_head_q <= free_head_n;
			list_head_q <= list_head_n;
			fresh_q     <= fresh_n;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q  <= node_n;
		count_q <= count_n;
		if (lk_re) begin
			raddr_s1 <= lk_raddr;
			fresh_s1 <= (LW'(lk_raddr) >= fresh_q);
		end
		if (emit) begin
			out_status_q  <= e_status;
			out_element_q <= e_element;
			out_last_q    <= e_last;
		end
	end

	assign out_ch.valid   = out_v_q;
	assign out_ch.status  = out_status_q;
	assign out_ch.element = out_element_q;
	assign out_ch.last    = out_last_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> (state_q == llsfl_pkg::ST_IDLE))
		else $error("input ready outside idle");

	a_fresh_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (fresh_q >= $past(fresh_q)) && (fresh_q <= LINK_NULL))
		else $error("fresh node count moved backward or past pool size");

	a_link_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		lk_we |-> ((state_q == llsfl_pkg::ST_INS) || (state_q == llsfl_pkg::ST_DEL)))
		else $error("link write outside insert or delete");

	a_overflow_now: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_ch.kind == llsfl_pkg::KIND_INSERT) && (free_head_q == LINK_NULL))
		|=> (out_v_q && (out_status_q == llsfl_pkg::STATUS_OVERFLOW) && out_last_q))
		else $error("overflow not reported at once");

	a_heads_range: assert property (@(posedge clk) disable iff (!arst_n)
		(list_head_q <= LINK_NULL) && (free_head_q <= LINK_NULL))
		else $error("head pointer out of range");

endmodule

FILE: hw/rtl/llsfl_ram.sv
`timescale 1ns / 1ps

module llsfl_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: tb/sv/linked_list_stack_with_free_list_test.sv
`timescale 1ns / 1ps

module linked_list_stack_with_free_list_test;

	localparam int unsigned NODES = 16;
	localparam int unsigned IDX_W = $clog2(NODES);
	localparam int unsigned LINK_W = $clog2(NODES + 1);
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODES);
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned DEFAULT_IDLE_PCT = 11;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic               last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;

	llsfl_in_if  in_ch();
	llsfl_out_if out_ch();

	linked_list_stack_with_free_list #(.NODES(NODES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #5 clk = ~clk;

	logic signed [31:0] pool_value [NODES];
	logic [LINK_W-1:0]  pool_next [NODES];
	logic [LINK_W-1:0]  active_head;
	logic [LINK_W-1:0]  spare_head;
	int unsigned        list_len;

	list_result_t list_results[$];

	int unsigned src_idle_pct = DEFAULT_IDLE_PCT;
	int unsigned sink_stall_pct = DEFAULT_IDLE_PCT;
	int unsigned sink_hold_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	function automatic void clear_pool();
		for (int i = 0; i < NODES; i++) begin
			pool_value[i] = '0;
			pool_next[i] = LINK_W'(i + 1);
		end
		pool_next[NODES-1] = LINK_NULL;
		active_head = LINK_NULL;
		spare_head = '0;
		list_len = 0;
	endfunction

	function automatic void queue_result(logic [1:0] status, logic signed [31:0] element,
			logic last);
		list_result_t r;
		r.status = status;
		r.element = element;
		r.last = last;
		list_results.push_back(r);
	endfunction

	function automatic void apply_list_op(logic [1:0] kind, logic signed [31:0] value);
		logic [LINK_W-1:0] node;
		logic [LINK_W-1:0] ptr;
		int unsigned n;
		case (kind)
			llsfl_pkg::KIND_INSERT: begin
				if (spare_head == LINK_NULL) begin
					queue_result(llsfl_pkg::STATUS_OVERFLOW, '0, 1'b1);
				end else begin
					node = spare_head;
					spare_head = pool_next[node[IDX_W-1:0]];
					pool_value[node[IDX_W-1:0]] = value;
					pool_next[node[IDX_W-1:0]] = active_head;
					active_head = node;
					list_len++;
					queue_result(llsfl_pkg::STATUS_DONE, '0, 1'b1);
				end
			end
			llsfl_pkg::KIND_DELETE: begin
				if (active_head == LINK_NULL) begin
					queue_result(llsfl_pkg::STATUS_EMPTY, '0, 1'b1);
				end else begin
					node = active_head;
					active_head = pool_next[node[IDX_W-1:0]];
					pool_next[node[IDX_W-1:0]] = spare_head;
					spare_head = node;
					list_len--;
					queue_result(llsfl_pkg::STATUS_DONE, '0, 1'b1);
				end
			end
			llsfl_pkg::KIND_TRAVERSE: begin
				if (active_head == LINK_NULL) begin
					queue_result(llsfl_pkg::STATUS_EMPTY, '0, 1'b1);
				end else begin
					n = 0;
					ptr = active_head;
					while (ptr < NODES && n < NODES) begin
						queue_result(llsfl_pkg::STATUS_ELEMENT,
							pool_value[ptr[IDX_W-1:0]], 1'b0);
						n++;
						ptr = pool_next[ptr[IDX_W-1:0]];
					end
					list_results[list_results.size()-1].last = 1'b1;
				end
			end
			default: begin
				queue_result(llsfl_pkg::STATUS_DONE, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", what);
	endfunction

	function automatic logic signed [31:0] draw_value();
		case ($urandom_range(39))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [1:0] draw_kind(int unsigned insert_pct);
		int unsigned r;
		r = $urandom_range(99);
		if (r < insert_pct)
			return llsfl_pkg::KIND_INSERT;
		else if (r < insert_pct + 15)
			return llsfl_pkg::KIND_TRAVERSE;
		else if (r < insert_pct + 18)
			return KIND_UNUSED;
		return llsfl_pkg::KIND_DELETE;
	endfunction

	task automatic send_item(input logic [1:0] kind, input logic signed [31:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.kind <= 2'($urandom());
			in_ch.value <= $urandom();
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.value <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		apply_list_op(kind, value);
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		in_ch.valid <= 1'b0;
		while (list_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_ops(input int unsigned count, input int unsigned insert_pct);
		for (int i = 0; i < count; i++)
			send_item(draw_kind(insert_pct), draw_value());
	endtask

	task automatic test_empty_and_extremes();
		send_item(llsfl_pkg::KIND_TRAVERSE, draw_value());
		send_item(llsfl_pkg::KIND_DELETE, draw_value());
		send_item(KIND_UNUSED, draw_value());
		send_item(llsfl_pkg::KIND_INSERT, 32'sh7fffffff);
		send_item(llsfl_pkg::KIND_INSERT, 32'sh80000000);
		send_item(llsfl_pkg::KIND_INSERT, 32'sh0);
		send_item(llsfl_pkg::KIND_INSERT, -32'sd1);
		send_item(llsfl_pkg::KIND_TRAVERSE, draw_value());
		send_item(llsfl_pkg::KIND_DELETE, draw_value());
		send_item(llsfl_pkg::KIND_TRAVERSE, draw_value());
	endtask

	task automatic test_full_pool();
		while (list_len < NODES)
			send_item(llsfl_pkg::KIND_INSERT, draw_value());
		send_item(llsfl_pkg::KIND_INSERT, draw_value());
		send_item(llsfl_pkg::KIND_TRAVERSE, draw_value());
		send_item(llsfl_pkg::KIND_DELETE, draw_value());
		send_item(llsfl_pkg::KIND_INSERT, draw_value());
		send_item(llsfl_pkg::KIND_TRAVERSE, draw_value());
	endtask

	task automatic test_random_fill_drain();
		for (int round = 0; round < 2; round++) begin
			run_random_ops(40, 70);
			run_random_ops(40, 25);
		end
	endtask

	task automatic test_no_idling();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		run_random_ops(60, 45);
		src_idle_pct = DEFAULT_IDLE_PCT;
		sink_stall_pct = DEFAULT_IDLE_PCT;
	endtask

	task automatic test_output_hold();
		sink_hold_cycles = 300;
		run_random_ops(20, 50);
	endtask

	task automatic test_sender_pause();
		run_random_ops(20, 50);
		wait_results_drained();
		run_random_ops(20, 40);
	endtask

	task automatic finish_run();
		wait_results_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && list_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	endtask

	initial begin : sink_ready_driver
		int unsigned hold;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_cycles != 0) begin
				hold = sink_hold_cycles;
				sink_hold_cycles = 0;
				out_ch.ready <= 1'b0;
				repeat (hold)
					@(negedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (list_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result: status %0d element %0d last %0d",
					out_ch.status, out_ch.element, out_ch.last));
			end else begin
				want = list_results.pop_front();
				if (out_ch.status !== want.status || out_ch.element !== want.element ||
						out_ch.last !== want.last)
					report_mismatch($sformatf({"result mismatch: expected %0d/%0d/%0d, ",
						"got %0d/%0d/%0d (status/element/last)"},
						want.status, want.element, want.last,
						out_ch.status, out_ch.element, out_ch.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = llsfl_pkg::KIND_INSERT;
		in_ch.value = '0;
		clear_pool();
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_and_extremes();
		test_full_pool();
		test_random_fill_drain();
		test_no_idling();
		test_output_hold();
		test_sender_pause();
		finish_run();
	end

endmodule
